// File: rtl/core/saq_pkg.sv
// Shared types and constants for the stop-and-wait ARQ sender.
package saq_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SeqW = 32;
  localparam int unsigned LenW = 16;
  localparam int unsigned OffW = 33;
  localparam int unsigned TickW = 9;
  localparam int unsigned ToW = 8;

  localparam logic [CfgIdxW-1:0] CfgFileSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPayloadSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeoutTicks = 2'd2;

  localparam logic [LenW-1:0] PayloadSizeRst = 16'd1024;
  localparam logic [ToW-1:0] TimeoutTicksRst = 8'd2;
  localparam logic [TickW-1:0] TickMax = '1;

  typedef enum logic [1:0] {
    ActStart = 2'd0,
    ActTick  = 2'd1,
    ActAck   = 2'd2,
    ActNone  = 2'd3
  } saq_action_e;

  typedef enum logic [1:0] {
    KindNew      = 2'd0,
    KindTimeout  = 2'd1,
    KindBadAck   = 2'd2,
    KindComplete = 2'd3
  } saq_kind_e;

  typedef struct packed {
    logic [SeqW-1:0] file_bytes;
    logic [LenW-1:0] frame_max;
    logic [ToW-1:0]  timeout_ticks;
  } saq_cfg_t;

  typedef struct packed {
    logic [OffW-1:0]  bytes_sent;
    logic [SeqW-1:0]  expected_ack;
    logic [SeqW-1:0]  current_seq;
    logic [LenW-1:0]  current_len;
    logic             active;
    logic [TickW-1:0] ticks;
  } saq_state_t;

  typedef struct packed {
    saq_action_e     action;
    logic [SeqW-1:0] ack_seq;
    logic [LenW-1:0] ack_len;
  } saq_item_t;

  typedef struct packed {
    saq_kind_e       kind;
    logic [SeqW-1:0] frame_seq;
    logic [LenW-1:0] frame_len;
    logic [OffW-1:0] frame_offset;
  } saq_result_t;

endpackage

// File: rtl/core/stop_and_wait_arq_sender.sv
// Stop-and-wait ARQ sender top level: input register, step logic, result register.
// Takes one event word per clock (start, tick, ack or none) unless in_stall_o is high, and gives
// at most one frame word per event: a new frame, a resend or a completion. An event sits
// in the input register while the step logic works on it against the protocol state,
// and its result is then captured in the output register.
// Sustained rate is one event per cycle when the output is not stalled;
// a stalled output register holds the step stage, and the input register then stalls.
module stop_and_wait_arq_sender (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [saq_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [saq_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [saq_pkg::SeqW-1:0]      ack_seq_i,
  input  logic [saq_pkg::LenW-1:0]      ack_len_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [saq_pkg::SeqW-1:0]      frame_seq_o,
  output logic [saq_pkg::LenW-1:0]      frame_len_o,
  output logic [saq_pkg::OffW-1:0]      frame_offset_o
);
  import saq_pkg::*;

  saq_cfg_t    cfg;
  saq_item_t   item_q;
  logic        item_valid_q;
  saq_state_t  state_q, state_d;
  saq_result_t res_d, out_q;
  logic        res_valid_d, out_valid_q;
  logic        out_free, advance, in_take;

  saq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  saq_step u_step (
    .cfg_i       (cfg),
    .state_i     (state_q),
    .item_i      (item_q),
    .state_o     (state_d),
    .res_valid_o (res_valid_d),
    .res_o       (res_d)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign advance = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (in_take || advance) begin
        item_valid_q <= in_take;
      end
      if (out_free) begin
        out_valid_q <= advance && res_valid_d;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action <= saq_action_e'(action_i);
      item_q.ack_seq <= ack_seq_i;
      item_q.ack_len <= ack_len_i;
    end
    if (advance && res_valid_d && out_free) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = out_q.kind;
  assign frame_seq_o = out_q.frame_seq;
  assign frame_len_o = out_q.frame_len;
  assign frame_offset_o = out_q.frame_offset;

endmodule

// File: rtl/core/saq_cfg.sv
// Configuration registers of the ARQ sender.
module saq_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [saq_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [saq_pkg::CfgDataW-1:0]   cfg_data_i,
  output saq_pkg::saq_cfg_t              cfg_o
);
  import saq_pkg::*;

  saq_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgFileSize:     cfg_d.file_bytes = cfg_data_i;
        CfgPayloadSize:  cfg_d.frame_max = cfg_data_i[LenW-1:0];
        CfgTimeoutTicks: cfg_d.timeout_ticks = cfg_data_i[ToW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.file_bytes <= '0;
      cfg_q.frame_max <= PayloadSizeRst;
      cfg_q.timeout_ticks <= TimeoutTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/saq_step.sv
// Next-state and result logic for one event word.
module saq_step (
  input  saq_pkg::saq_cfg_t    cfg_i,
  input  saq_pkg::saq_state_t  state_i,
  input  saq_pkg::saq_item_t   item_i,
  output saq_pkg::saq_state_t  state_o,
  output logic                 res_valid_o,
  output saq_pkg::saq_result_t res_o
);
  import saq_pkg::*;

  logic [OffW-1:0]  total;
  logic [OffW-1:0]  base_bytes;
  logic [SeqW-1:0]  base_ack;
  logic [OffW-1:0]  remaining;
  logic [LenW-1:0]  limit;
  logic [LenW-1:0]  new_len;
  logic [SeqW-1:0]  new_ack;
  logic [OffW-1:0]  resend_off;
  logic [TickW-1:0] tick_inc;
  logic             ack_good;

  always_comb begin
    total = {1'b0, cfg_i.file_bytes} + OffW'(1);
    base_bytes = (item_i.action == ActStart) ? '0 : state_i.bytes_sent;
    base_ack = (item_i.action == ActStart) ? '0 : state_i.expected_ack;
    remaining = total - base_bytes;
    limit = (cfg_i.frame_max == '0) ? LenW'(1) : cfg_i.frame_max;
    new_len = (remaining <= {{(OffW-LenW){1'b0}}, limit}) ? remaining[LenW-1:0] : limit;
    new_ack = (base_bytes == '0) ? {{(SeqW-LenW){1'b0}}, new_len} + SeqW'(1)
                                 : base_ack + {{(SeqW-LenW){1'b0}}, new_len};
    resend_off = state_i.bytes_sent - {{(OffW-LenW){1'b0}}, state_i.current_len};
    tick_inc = (state_i.ticks < TickMax) ? state_i.ticks + TickW'(1) : state_i.ticks;
    ack_good = (item_i.ack_seq == state_i.expected_ack) &&
               (item_i.ack_len == state_i.current_len);
  end

  always_comb begin
    state_o = state_i;
    res_valid_o = 1'b0;
    res_o.kind = KindNew;
    res_o.frame_seq = state_i.current_seq;
    res_o.frame_len = state_i.current_len;
    res_o.frame_offset = resend_off;
    priority if (item_i.action == ActStart && !state_i.active) begin
      res_valid_o = 1'b1;
      res_o.frame_seq = '0;
      res_o.frame_len = new_len;
      res_o.frame_offset = '0;
      state_o.current_seq = '0;
      state_o.current_len = new_len;
      state_o.expected_ack = new_ack;
      state_o.bytes_sent = {{(OffW-LenW){1'b0}}, new_len};
      state_o.ticks = '0;
      state_o.active = 1'b1;
    end else if (!state_i.active || item_i.action == ActStart ||
                 item_i.action == ActNone) begin
      state_o = state_i;
    end else if (item_i.action == ActTick) begin
      state_o.ticks = tick_inc;
      if (tick_inc > {{(TickW-ToW){1'b0}}, cfg_i.timeout_ticks}) begin
        res_valid_o = 1'b1;
        res_o.kind = KindTimeout;
        state_o.ticks = '0;
      end
    end else if (!ack_good) begin
      res_valid_o = 1'b1;
      res_o.kind = KindBadAck;
      state_o.ticks = '0;
    end else if (state_i.bytes_sent >= total) begin
      res_valid_o = 1'b1;
      res_o.kind = KindComplete;
      res_o.frame_seq = '0;
      res_o.frame_len = '0;
      res_o.frame_offset = state_i.bytes_sent;
      state_o.active = 1'b0;
      state_o.ticks = '0;
    end else begin
      res_valid_o = 1'b1;
      res_o.frame_seq = state_i.expected_ack;
      res_o.frame_len = new_len;
      res_o.frame_offset = state_i.bytes_sent;
      state_o.current_seq = state_i.expected_ack;
      state_o.current_len = new_len;
      state_o.expected_ack = new_ack;
      state_o.bytes_sent = state_i.bytes_sent + {{(OffW-LenW){1'b0}}, new_len};
      state_o.ticks = '0;
    end
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the stop-and-wait ARQ sender: random traffic checked against a protocol model.
module tb_top;
  import saq_pkg::*;

  typedef struct {
    saq_item_t   ev;
    bit          has_frame;
    saq_result_t frame;
  } arq_event_t;

  typedef enum logic [1:0] {
    StallNone,
    StallSparse,
    StallPeriodic,
    StallHeavy
  } stall_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CfgFileSize;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          action = ActNone;
  logic [SeqW-1:0]     ack_seq = '0;
  logic [LenW-1:0]     ack_len = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          kind;
  logic [SeqW-1:0]     frame_seq;
  logic [LenW-1:0]     frame_len;
  logic [OffW-1:0]     frame_offset;

  stop_and_wait_arq_sender dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .ack_seq_i      (ack_seq),
    .ack_len_i      (ack_len),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind),
    .frame_seq_o    (frame_seq),
    .frame_len_o    (frame_len),
    .frame_offset_o (frame_offset)
  );

  // protocol model state and its copy of the registers
  logic [OffW-1:0]  sent_bytes = '0;
  logic [SeqW-1:0]  ack_due = '0;
  logic [SeqW-1:0]  cur_seq = '0;
  logic [LenW-1:0]  cur_len = '0;
  logic             busy = 1'b0;
  logic [TickW-1:0] tick_count = '0;
  logic [SeqW-1:0]  cfg_file = '0;
  logic [LenW-1:0]  cfg_payload = PayloadSizeRst;
  logic [ToW-1:0]   cfg_timeout = TimeoutTicksRst;

  arq_event_t  events_pending[$];
  saq_result_t frames_due[$];
  arq_event_t  on_wire;
  saq_result_t want;
  int          errors = 0;
  int          queued_events = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  logic        next_valid;
  stall_mode_e stall_mode = StallNone;
  int          mode_left = 0;
  logic [2:0]  stall_phase = '0;
  logic        next_stall;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50000000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic next_frame(output saq_result_t res);
    logic [33:0]     remaining;
    logic [LenW-1:0] limit;
    logic [LenW-1:0] len;
    remaining = {2'b00, cfg_file} + 34'd1 - {1'b0, sent_bytes};
    limit = (cfg_payload == '0) ? 16'd1 : cfg_payload;
    len = (remaining <= {18'd0, limit}) ? remaining[15:0] : limit;
    res.kind = KindNew;
    res.frame_seq = ack_due;
    res.frame_len = len;
    res.frame_offset = sent_bytes;
    cur_seq = ack_due;
    cur_len = len;
    ack_due = (sent_bytes == '0) ? {16'd0, len} + 32'd1 : ack_due + {16'd0, len};
    sent_bytes = sent_bytes + {17'd0, len};
    tick_count = '0;
    busy = 1'b1;
  endtask

  task automatic resend_frame(input saq_kind_e why, output saq_result_t res);
    res.kind = why;
    res.frame_seq = cur_seq;
    res.frame_len = cur_len;
    res.frame_offset = sent_bytes - {17'd0, cur_len};
    tick_count = '0;
  endtask

  task automatic arq_step(input saq_action_e act, input logic [SeqW-1:0] aseq,
                          input logic [LenW-1:0] alen, output bit has,
                          output saq_result_t res);
    has = 1'b0;
    res = '0;
    if (act == ActStart) begin
      if (!busy) begin
        sent_bytes = '0;
        ack_due = '0;
        next_frame(res);
        has = 1'b1;
      end
    end else if (busy && act == ActTick) begin
      if (tick_count != TickMax) tick_count = tick_count + 1'b1;
      if (tick_count > {1'b0, cfg_timeout}) begin
        resend_frame(KindTimeout, res);
        has = 1'b1;
      end
    end else if (busy && act == ActAck) begin
      has = 1'b1;
      if (aseq != ack_due || alen != cur_len) begin
        resend_frame(KindBadAck, res);
      end else if ({1'b0, sent_bytes} >= {2'b00, cfg_file} + 34'd1) begin
        busy = 1'b0;
        tick_count = '0;
        res.kind = KindComplete;
        res.frame_seq = '0;
        res.frame_len = '0;
        res.frame_offset = sent_bytes;
      end else begin
        next_frame(res);
      end
    end
  endtask

  task automatic queue_event(input saq_action_e act, input logic [SeqW-1:0] aseq,
                             input logic [LenW-1:0] alen);
    arq_event_t e;
    queued_events++;
    e.ev.action = act;
    e.ev.ack_seq = aseq;
    e.ev.ack_len = alen;
    arq_step(act, aseq, alen, e.has_frame, e.frame);
    events_pending.push_back(e);
  endtask

  task automatic queue_noise(input int n);
    repeat (n) queue_event(saq_action_e'($urandom_range(0, 3)), $urandom, LenW'($urandom));
  endtask

  task automatic queue_bad_ack();
    case ($urandom_range(0, 2))
      0: queue_event(ActAck, ack_due ^ (32'd1 << $urandom_range(0, 31)), cur_len);
      1: queue_event(ActAck, ack_due, cur_len ^ (16'd1 << $urandom_range(0, 15)));
      default: queue_event(ActAck, $urandom, LenW'($urandom));
    endcase
  endtask

  task automatic run_transfer(input int max_steps);
    int steps;
    int r;
    int n;
    steps = 0;
    queue_event(ActStart, $urandom, LenW'($urandom));
    while (busy && steps < max_steps) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        queue_event(ActAck, ack_due, cur_len);
      end else if (r < 80) begin
        queue_bad_ack();
      end else if (r < 93) begin
        n = (cfg_timeout > 8 && $urandom_range(0, 7) == 0) ? cfg_timeout + 2
                                                            : $urandom_range(1, 4);
        repeat (n) queue_event(ActTick, $urandom, LenW'($urandom));
      end else if (r < 97) begin
        queue_event(ActNone, $urandom, LenW'($urandom));
      end else begin
        queue_event(ActStart, $urandom, LenW'($urandom));
      end
      steps++;
    end
  endtask

  task automatic set_config(input logic [SeqW-1:0] file, input logic [LenW-1:0] payload,
                            input logic [ToW-1:0] timeout);
    cfg_we <= 1'b1;
    cfg_index <= CfgFileSize;
    cfg_data <= file;
    @(posedge clk_i);
    cfg_index <= CfgPayloadSize;
    cfg_data <= {16'd0, payload};
    @(posedge clk_i);
    cfg_index <= CfgTimeoutTicks;
    cfg_data <= {24'd0, timeout};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cfg_file = file;
    cfg_payload = payload;
    cfg_timeout = timeout;
  endtask

  task automatic wait_idle();
    while (events_pending.size() != 0 || in_valid || frames_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        if (on_wire.has_frame) frames_due.push_back(on_wire.frame);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (events_pending.size() != 0) begin
          on_wire = events_pending.pop_front();
          next_valid = 1'b1;
          action <= on_wire.ev.action;
          ack_seq <= on_wire.ev.ack_seq;
          ack_len <= on_wire.ev.ack_len;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // receiver: stall pattern switches between modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      stall_phase = stall_phase + 1'b1;
      case (stall_mode)
        StallSparse:   next_stall = ($urandom_range(0, 2) == 0);
        StallPeriodic: next_stall = (stall_phase < 3'd3);
        StallHeavy:    next_stall = ($urandom_range(0, 9) < 7);
        default:       next_stall = 1'b0;
      endcase
      out_stall <= next_stall;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word: expected none actual kind=%0d seq=%h len=%h off=%h",
                 $time, kind, frame_seq, frame_len, frame_offset);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, kind);
          errors++;
        end
        if (frame_seq !== want.frame_seq) begin
          $display("%0t: frame_seq mismatch: expected %h actual %h",
                   $time, want.frame_seq, frame_seq);
          errors++;
        end
        if (frame_len !== want.frame_len) begin
          $display("%0t: frame_len mismatch: expected %h actual %h",
                   $time, want.frame_len, frame_len);
          errors++;
        end
        if (frame_offset !== want.frame_offset) begin
          $display("%0t: frame_offset mismatch: expected %h actual %h",
                   $time, want.frame_offset, frame_offset);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [LenW-1:0] payload;
    logic [SeqW-1:0] file;
    logic [ToW-1:0]  timeout;
    int              eff;
    int              r;
    int              guard;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of the registers; ignored words while idle and while active
    queue_event(ActTick, '0, '0);
    queue_event(ActAck, '1, '1);
    queue_event(ActNone, '1, '1);
    queue_event(ActStart, '0, '0);
    queue_event(ActStart, '1, '1);
    queue_event(ActNone, '0, '0);
    repeat (3) queue_event(ActTick, '0, '0);
    queue_event(ActAck, ack_due ^ 32'h8000_0000, cur_len);
    queue_event(ActAck, ack_due, 16'hFFFF);
    queue_event(ActAck, ack_due, cur_len);
    wait_idle();

    // zero payload size, zero timeout, largest file
    set_config('1, '0, '0);
    queue_event(ActStart, '0, '0);
    queue_event(ActTick, '0, '0);
    queue_event(ActAck, ack_due, cur_len);
    queue_event(ActAck, '1, '1);
    wait_idle();
    // file shrinks mid-transfer
    set_config(32'd2, 16'hFFFF, 8'd1);
    queue_event(ActAck, ack_due, cur_len);
    queue_event(ActAck, ack_due, cur_len);
    wait_idle();
    set_config(32'd10, 16'd4, 8'd3);
    queue_event(ActStart, '0, '0);
    queue_event(ActAck, ack_due, cur_len);
    wait_idle();
    set_config(32'd3, 16'd4, 8'd3);
    queue_event(ActAck, ack_due, cur_len);
    wait_idle();

    queued_events = 0;
    while (queued_events < 1320) begin
      r = $urandom_range(0, 99);
      if (r < 5) payload = '0;
      else if (r < 10) payload = 16'hFFFF;
      else payload = LenW'($urandom_range(1, 300));
      eff = (payload == '0) ? 1 : payload;
      file = ($urandom_range(0, 99) < 15) ? $urandom : $urandom_range(0, 6 * eff);
      r = $urandom_range(0, 9);
      if (r == 0) timeout = 8'd255;
      else if (r == 1) timeout = '0;
      else timeout = ToW'($urandom_range(1, 5));
      set_config(file, payload, timeout);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 8));
        run_transfer(60);
      end
      wait_idle();
    end

    while (events_pending.size() != 0 || in_valid) @(posedge clk_i);
    guard = 0;
    while (frames_due.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (frames_due.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, frames_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
